### src/rgbk_pkg.sv
`default_nettype none
package rgbk_pkg;

  localparam int PIX_W      = 24;   // packed RGB word: red [7:0], green [15:8], blue [23:16]
  localparam int CH_W       = 8;
  localparam int ROW_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int KERNEL     = 3;
  localparam int PIX_MAX    = 255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEFF_LEFT   = 3'd0,
    REG_COEFF_MID    = 3'd1,
    REG_COEFF_RIGHT  = 3'd2,
    REG_FRAME_WIDTH  = 3'd3,
    REG_FRAME_HEIGHT = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_EDGE,
    KIND_CENTER,
    KIND_CONV,
    KIND_DRAIN
  } out_kind_t;

  // control for the word in the memory-read stage
  typedef struct packed {
    logic      pix;        // pixel word: writes line stores, shifts window
    logic      emit;       // produces an output word
    out_kind_t kind;
    logic      last;
    logic      sel_lower;  // drain: take lower line store
  } s1_ctrl_t;

endpackage
`default_nettype wire

### src/rgbk_if.sv
`default_nettype none
interface rgbk_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pix_red;
  logic [7:0] pix_green;
  logic [7:0] pix_blue;
  logic       drain;
  modport source (output valid, pix_red, pix_green, pix_blue, drain, input ready);
  modport sink   (input valid, pix_red, pix_green, pix_blue, drain, output ready);
endinterface

interface rgbk_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_last;
  modport source (output valid, out_red, out_green, out_blue, frame_last, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_last, output ready);
endinterface

interface rgbk_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### src/rgbk_seq.sv
`default_nettype none
module rgbk_seq #(
  parameter int MAX_WIDTH = 4096,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        adv,
  input  wire logic                        accept,
  input  wire logic                        drain,
  input  wire logic [rgbk_pkg::PIX_W-1:0]  px,
  input  wire logic [rgbk_pkg::ROW_W-1:0]  cfg_width,
  input  wire logic [rgbk_pkg::ROW_W-1:0]  cfg_height,
  output logic      [AW-1:0]               rd_addr,
  output logic      [AW-1:0]               edge_addr,
  output rgbk_pkg::s1_ctrl_t               s1_ctrl,
  output logic      [AW-1:0]               s1_col,
  output logic      [AW-1:0]               s1_edge,
  output logic      [rgbk_pkg::PIX_W-1:0]  s1_px
);

  logic [AW-1:0]              in_column, out_column;
  logic [rgbk_pkg::ROW_W-1:0] in_row, out_row;
  logic                       frame_received;

  logic [rgbk_pkg::ROW_W:0]   w_ext;
  logic [AW-1:0]              wm1, col;
  logic [rgbk_pkg::ROW_W-1:0] hm1;
  logic                       col_last, row_last, emit, out_last, do_pix, do_drain, out_step;
  rgbk_pkg::out_kind_t        kind;

  always_comb begin
    w_ext = {1'b0, cfg_width};
    if (cfg_width == '0) begin
      wm1 = '0;
    end else if (w_ext > (rgbk_pkg::ROW_W+1)'(MAX_WIDTH)) begin
      wm1 = AW'(MAX_WIDTH - 1);
    end else begin
      wm1 = AW'(w_ext - 1'b1);
    end
    hm1 = (cfg_height == '0) ? '0 : cfg_height - 1'b1;
    // a column past a shrunk width counts as the last column
    col      = (in_column > wm1) ? wm1 : in_column;
    col_last = (col == wm1);
    row_last = (in_row >= hm1);
    emit     = (in_row >= rgbk_pkg::ROW_W'(2)) ||
               ((in_row == rgbk_pkg::ROW_W'(1)) && (col != '0));
    if (col == '0) begin
      kind = rgbk_pkg::KIND_EDGE;
    end else if ((col >= AW'(2)) && (in_row >= rgbk_pkg::ROW_W'(2))) begin
      kind = rgbk_pkg::KIND_CONV;
    end else begin
      kind = rgbk_pkg::KIND_CENTER;
    end
    out_last  = (out_row >= hm1) && (out_column >= wm1);
    do_pix    = accept && !drain && !frame_received;
    do_drain  = accept && drain && frame_received;
    out_step  = (do_pix && emit) || do_drain;
    rd_addr   = drain ? out_column : col;
    edge_addr = wm1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column      <= '0;
      in_row         <= '0;
      out_column     <= '0;
      out_row        <= '0;
      frame_received <= 1'b0;
      s1_ctrl        <= '0;
    end else if (adv) begin
      s1_ctrl.pix       <= do_pix;
      s1_ctrl.emit      <= out_step;
      s1_ctrl.kind      <= do_drain ? rgbk_pkg::KIND_DRAIN : kind;
      s1_ctrl.last      <= out_last;
      s1_ctrl.sel_lower <= (out_row >= hm1);
      if (do_pix) begin
        if (col_last) begin
          in_column <= '0;
          if (row_last) begin
            in_row         <= '0;
            frame_received <= 1'b1;
          end else begin
            in_row <= in_row + 1'b1;
          end
        end else begin
          in_column <= col + 1'b1;
        end
      end
      if (out_step) begin
        if (out_last) begin
          out_column <= '0;
          out_row    <= '0;
        end else if (out_column >= wm1) begin
          out_column <= '0;
          out_row    <= out_row + 1'b1;
        end else begin
          out_column <= out_column + 1'b1;
        end
      end
      if (do_drain && out_last) begin
        frame_received <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_col  <= rd_addr;
      s1_edge <= wm1;
      s1_px   <= px;
    end
  end

endmodule
`default_nettype wire

### src/rgbk_line_store.sv
`default_nettype none
module rgbk_line_store #(
  parameter int MAX_WIDTH = 4096,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        adv,
  input  wire logic [AW-1:0]               rd_addr,
  input  wire logic [AW-1:0]               edge_addr,
  input  wire logic                        wr_en,
  input  wire logic [AW-1:0]               s1_col,
  input  wire logic [AW-1:0]               s1_edge,
  input  wire logic [rgbk_pkg::PIX_W-1:0]  s1_px,
  output logic      [rgbk_pkg::PIX_W-1:0]  up,
  output logic      [rgbk_pkg::PIX_W-1:0]  mid,
  output logic      [rgbk_pkg::PIX_W-1:0]  edge_px
);

  logic [rgbk_pkg::PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [rgbk_pkg::PIX_W-1:0] lower_mem [MAX_WIDTH];

  logic [rgbk_pkg::PIX_W-1:0] rd_up, rd_low, rd_edge;

  // last write, for a read issued in the same cycle as that write
  logic                       lw_valid;
  logic [AW-1:0]              lw_addr;
  logic [rgbk_pkg::PIX_W-1:0] lw_up, lw_low;

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_up   <= upper_mem[rd_addr];
      rd_edge <= upper_mem[edge_addr];
      rd_low  <= lower_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && wr_en) begin
      upper_mem[s1_col] <= mid;
      lower_mem[s1_col] <= s1_px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else if (adv && wr_en) begin
      lw_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && wr_en) begin
      lw_addr <= s1_col;
      lw_up   <= mid;
      lw_low  <= s1_px;
    end
  end

  always_comb begin
    up      = (lw_valid && (lw_addr == s1_col))  ? lw_up  : rd_up;
    mid     = (lw_valid && (lw_addr == s1_col))  ? lw_low : rd_low;
    edge_px = (lw_valid && (lw_addr == s1_edge)) ? lw_up  : rd_edge;
  end

endmodule
`default_nettype wire

### src/rgbk_filter.sv
`default_nettype none
module rgbk_filter #(
  parameter int COEFF_BITS = 8
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  input  wire logic                                       adv,
  input  wire rgbk_pkg::s1_ctrl_t                         s1_ctrl,
  input  wire logic [rgbk_pkg::PIX_W-1:0]                 up,
  input  wire logic [rgbk_pkg::PIX_W-1:0]                 mid,
  input  wire logic [rgbk_pkg::PIX_W-1:0]                 edge_px,
  input  wire logic [rgbk_pkg::PIX_W-1:0]                 s1_px,
  input  wire logic [2:0][rgbk_pkg::CFG_DATA_W-1:0]       coeff,
  output logic                                            out_valid,
  output logic      [rgbk_pkg::PIX_W-1:0]                 out_px,
  output logic                                            out_last
);

  localparam int TAPS = rgbk_pkg::KERNEL * rgbk_pkg::KERNEL;
  localparam int PW   = COEFF_BITS + rgbk_pkg::CH_W + 1;
  localparam int SW   = PW + 4;
  localparam int EXTW = (3 * COEFF_BITS > rgbk_pkg::CFG_DATA_W) ?
                        3 * COEFF_BITS : rgbk_pkg::CFG_DATA_W;

  // window indexed [dy][dx], column dx=2 is the newest
  logic [rgbk_pkg::PIX_W-1:0] win [3][3];

  logic [rgbk_pkg::PIX_W-1:0] pass_next;
  logic                       s2_valid, s2_conv, s2_last;
  logic [rgbk_pkg::PIX_W-1:0] s2_pass;
  logic                       s3_valid, s3_conv, s3_last;
  logic [rgbk_pkg::PIX_W-1:0] s3_pass;

  logic signed [COEFF_BITS-1:0] coef [3][3];   // [dx][dy]
  logic signed [PW-1:0]         prod_next [3][TAPS];
  logic signed [PW-1:0]         s3_prod   [3][TAPS];
  logic [rgbk_pkg::PIX_W-1:0]   conv_px;

  always_comb begin
    logic [EXTW-1:0] ext;
    for (int dx = 0; dx < 3; dx++) begin
      ext = EXTW'(coeff[dx]);
      for (int dy = 0; dy < 3; dy++) begin
        coef[dx][dy] = ext[dy*COEFF_BITS +: COEFF_BITS];
      end
    end
  end

  always_comb begin
    unique case (s1_ctrl.kind)
      rgbk_pkg::KIND_EDGE:  pass_next = edge_px;
      rgbk_pkg::KIND_DRAIN: pass_next = s1_ctrl.sel_lower ? mid : up;
      default:              pass_next = win[1][2];  // becomes the center after the shift
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv && s1_ctrl.pix) begin
      for (int k = 0; k < 3; k++) begin
        win[k][0] <= win[k][1];
        win[k][1] <= win[k][2];
      end
      win[0][2] <= up;
      win[1][2] <= mid;
      win[2][2] <= s1_px;
    end
  end

  // nine taps per channel in parallel
  always_comb begin
    logic signed [rgbk_pkg::CH_W:0] pv;
    for (int ch = 0; ch < 3; ch++) begin
      for (int dy = 0; dy < 3; dy++) begin
        for (int dx = 0; dx < 3; dx++) begin
          pv = {1'b0, win[dy][dx][rgbk_pkg::CH_W*ch +: rgbk_pkg::CH_W]};
          prod_next[ch][dy*3+dx] = pv * coef[dx][dy];
        end
      end
    end
  end

  always_comb begin
    logic signed [SW-1:0] acc;
    for (int ch = 0; ch < 3; ch++) begin
      acc = '0;
      for (int k = 0; k < TAPS; k++) begin
        acc = acc + SW'(s3_prod[ch][k]);
      end
      if (acc < 0) begin
        conv_px[rgbk_pkg::CH_W*ch +: rgbk_pkg::CH_W] = '0;
      end else if (acc > SW'(rgbk_pkg::PIX_MAX)) begin
        conv_px[rgbk_pkg::CH_W*ch +: rgbk_pkg::CH_W] = rgbk_pkg::CH_W'(rgbk_pkg::PIX_MAX);
      end else begin
        conv_px[rgbk_pkg::CH_W*ch +: rgbk_pkg::CH_W] = acc[rgbk_pkg::CH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s2_valid  <= s1_ctrl.emit;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_conv <= (s1_ctrl.kind == rgbk_pkg::KIND_CONV);
      s2_last <= s1_ctrl.last;
      s2_pass <= pass_next;
      s3_conv <= s2_conv;
      s3_last <= s2_last;
      s3_pass <= s2_pass;
      s3_prod <= prod_next;
      out_px  <= s3_conv ? conv_px : s3_pass;
      out_last <= s3_last;
    end
  end

endmodule
`default_nettype wire

### src/rgb_kernel_convolution_unit.sv
`default_nettype none
// 3x3 RGB convolution filter, one pixel word per clock in raster order.
// Words in and out use valid/ready; the block takes a word every clock
// unless the output is full and stalled, and the whole pipeline stalls with it.
// A word's path: the memory read is issued at the edge that accepts it, then
// window/multiply, products register, and sum/clamp into the output register.
// A result appears one row plus one pixel behind the input; the last row plus
// one pixel of a frame is pushed out by drain words. Interior pixels get the
// signed kernel sum per channel, clamped to 0..255; border pixels pass as-is.
// Two line stores of MAX_WIDTH words each (registered synchronous read) hold the
// previous two rows; each pixel reads its column, writes it back shifted, and
// a last-write bypass covers the read that lands on the cycle of its write.
// The line stores come up unwritten and need no clearing pass.
// Config: write coefficients and frame size only while the block is idle.
module rgb_kernel_convolution_unit #(
  parameter int MAX_WIDTH  = 4096,
  parameter int COEFF_BITS = 8
) (
  input wire logic        clk,
  input wire logic        rst,
  rgbk_pix_if.sink        pix_in,
  rgbk_out_if.source      pix_out,
  rgbk_cfg_if.sink        cfg
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic [2:0][rgbk_pkg::CFG_DATA_W-1:0] coeff;
  logic [rgbk_pkg::ROW_W-1:0]           frame_width, frame_height;

  logic                       adv, accept;
  logic [rgbk_pkg::PIX_W-1:0] px;
  logic [AW-1:0]              rd_addr, edge_addr, s1_col, s1_edge;
  rgbk_pkg::s1_ctrl_t         s1_ctrl;
  logic [rgbk_pkg::PIX_W-1:0] s1_px, up, mid, edge_px;
  logic                       out_valid, out_last;
  logic [rgbk_pkg::PIX_W-1:0] out_px;

  // config registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff        <= '0;
      frame_width  <= rgbk_pkg::ROW_W'(1);
      frame_height <= rgbk_pkg::ROW_W'(1);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        rgbk_pkg::REG_COEFF_LEFT:   coeff[0]     <= cfg.data;
        rgbk_pkg::REG_COEFF_MID:    coeff[1]     <= cfg.data;
        rgbk_pkg::REG_COEFF_RIGHT:  coeff[2]     <= cfg.data;
        rgbk_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg.data[rgbk_pkg::ROW_W-1:0];
        rgbk_pkg::REG_FRAME_HEIGHT: frame_height <= cfg.data[rgbk_pkg::ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // one stall signal for every stage
  assign adv          = !out_valid || pix_out.ready;
  assign pix_in.ready = adv;
  assign accept       = pix_in.valid && adv;
  assign px           = {pix_in.pix_blue, pix_in.pix_green, pix_in.pix_red};

  rgbk_seq #(.MAX_WIDTH(MAX_WIDTH)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .accept     (accept),
    .drain      (pix_in.drain),
    .px         (px),
    .cfg_width  (frame_width),
    .cfg_height (frame_height),
    .rd_addr    (rd_addr),
    .edge_addr  (edge_addr),
    .s1_ctrl    (s1_ctrl),
    .s1_col     (s1_col),
    .s1_edge    (s1_edge),
    .s1_px      (s1_px)
  );

  rgbk_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_line_store (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .rd_addr   (rd_addr),
    .edge_addr (edge_addr),
    .wr_en     (s1_ctrl.pix),
    .s1_col    (s1_col),
    .s1_edge   (s1_edge),
    .s1_px     (s1_px),
    .up        (up),
    .mid       (mid),
    .edge_px   (edge_px)
  );

  rgbk_filter #(.COEFF_BITS(COEFF_BITS)) u_filter (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .s1_ctrl   (s1_ctrl),
    .up        (up),
    .mid       (mid),
    .edge_px   (edge_px),
    .s1_px     (s1_px),
    .coeff     (coeff),
    .out_valid (out_valid),
    .out_px    (out_px),
    .out_last  (out_last)
  );

  assign pix_out.valid      = out_valid;
  assign pix_out.out_red    = out_px[7:0];
  assign pix_out.out_green  = out_px[15:8];
  assign pix_out.out_blue   = out_px[23:16];
  assign pix_out.frame_last = out_last;

  // a drain word never writes the line stores
  a_drain_no_write: assert property (@(posedge clk) disable iff (rst)
    (s1_ctrl.emit && (s1_ctrl.kind == rgbk_pkg::KIND_DRAIN)) |-> !s1_ctrl.pix)
    else $error("drain word marked as pixel write");

  // a stalled memory-read stage keeps its control
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(s1_ctrl))
    else $error("stage control changed under stall");

  // the stage that writes the line stores advances only with the output side
  a_write_needs_adv: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pix_out.ready) |-> !pix_in.ready)
    else $error("input taken while output stalled");

endmodule
`default_nettype wire

### tb/sv/rgbk_checker.sv
module rgbk_checker (
  input  logic clk,
  input  logic rst,
  rgbk_pix_if  pix,
  rgbk_out_if  out,
  rgbk_cfg_if  cfg,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_DEPTH = 4096;
  localparam int COEF_W     = 8;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } filt_word_t;

  filt_word_t  filtered_q[$];

  logic [rgbk_pkg::PIX_W-1:0] row_prev2 [LINE_DEPTH];
  logic [rgbk_pkg::PIX_W-1:0] row_prev1 [LINE_DEPTH];
  logic [rgbk_pkg::PIX_W-1:0] win [3][3];
  logic [23:0]      coef_col [3];
  logic [12:0]      width_reg, height_reg;
  int               col_in, row_in, col_out, row_out;
  bit               frame_full;

  function automatic int eff_width();
    int w;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    return w;
  endfunction

  function automatic int eff_height();
    return (height_reg == 0) ? 1 : int'(height_reg);
  endfunction

  function automatic logic [7:0] clamp8(longint v);
    if (v > rgbk_pkg::PIX_MAX) return 8'(rgbk_pkg::PIX_MAX);
    if (v < 0) return 8'd0;
    return 8'(v);
  endfunction

  function automatic logic [rgbk_pkg::PIX_W-1:0] kernel_sum();
    logic [rgbk_pkg::PIX_W-1:0] res;
    longint acc;
    res = '0;
    for (int ch = 0; ch < 3; ch++) begin
      acc = 0;
      for (int dx = 0; dx < 3; dx++)
        for (int dy = 0; dy < 3; dy++)
          acc += longint'(win[dy][dx][8*ch +: 8]) *
                 longint'($signed(coef_col[dx][dy*COEF_W +: COEF_W]));
      res[8*ch +: 8] = clamp8(acc);
    end
    return res;
  endfunction

  // walk the output raster; 1 on the frame's final pixel
  function automatic bit step_out(int w, int h);
    bit last;
    last = (row_out + 1 >= h) && (col_out + 1 >= w);
    if (last) begin
      row_out = 0;
      col_out = 0;
    end else if (col_out + 1 >= w) begin
      col_out = 0;
      row_out++;
    end else begin
      col_out++;
    end
    return last;
  endfunction

  function automatic void push_word(logic [rgbk_pkg::PIX_W-1:0] px, bit last);
    filtered_q.push_back('{px[7:0], px[15:8], px[23:16], last});
  endfunction

  task automatic take_drain();
    int w, h;
    logic [rgbk_pkg::PIX_W-1:0] px;
    bit last;
    w = eff_width();
    h = eff_height();
    if (!frame_full) return;
    px = (row_out + 1 >= h) ? row_prev1[col_out] : row_prev2[col_out];
    last = step_out(w, h);
    if (last) frame_full = 0;
    push_word(px, last);
  endtask

  task automatic take_pixel(logic [rgbk_pkg::PIX_W-1:0] px);
    int w, h, c, r;
    logic [rgbk_pkg::PIX_W-1:0] left_px, up, mid, val;
    bit emit;
    w = eff_width();
    h = eff_height();
    if (frame_full) return;
    c = (col_in < w) ? col_in : w - 1;
    r = row_in;
    left_px = row_prev2[w-1];
    up  = row_prev2[c];
    mid = row_prev1[c];
    emit = (r >= 2) || (r == 1 && c >= 1);
    row_prev2[c] = mid;
    row_prev1[c] = px;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = up;
    win[1][2] = mid;
    win[2][2] = px;
    if (c + 1 >= w) begin
      col_in = 0;
      if (r + 1 >= h) begin
        row_in = 0;
        frame_full = 1;
      end else begin
        row_in = r + 1;
      end
    end else begin
      col_in = c + 1;
    end
    if (emit) begin
      if (c == 0) val = left_px;
      else if (c >= 2 && r >= 2) val = kernel_sum();
      else val = win[1][1];
      push_word(val, step_out(w, h));
    end
  endtask

  task automatic check_word();
    filt_word_t got, want;
    got = '{out.out_red, out.out_green, out.out_blue, out.frame_last};
    if (filtered_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%t unexpected word r=%0d g=%0d b=%0d last=%0b", $realtime,
                 got.red, got.green, got.blue, got.last);
      return;
    end
    want = filtered_q.pop_front();
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%t mismatch exp r=%0d g=%0d b=%0d last=%0b got r=%0d g=%0d b=%0d last=%0b",
                 $realtime, want.red, want.green, want.blue, want.last,
                 got.red, got.green, got.blue, got.last);
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      filtered_q.delete();
      for (int i = 0; i < LINE_DEPTH; i++) begin
        row_prev2[i] = '0;
        row_prev1[i] = '0;
      end
      for (int i = 0; i < 3; i++) begin
        coef_col[i] = '0;
        for (int j = 0; j < 3; j++) win[i][j] = '0;
      end
      width_reg = 13'd1;
      height_reg = 13'd1;
      col_in = 0;
      row_in = 0;
      col_out = 0;
      row_out = 0;
      frame_full = 0;
    end else begin
      if (out.valid && out.ready) check_word();
      if (cfg.valid && cfg.ready) begin
        case (rgbk_pkg::cfg_reg_t'(cfg.index))
          rgbk_pkg::REG_COEFF_LEFT:   coef_col[0] = cfg.data;
          rgbk_pkg::REG_COEFF_MID:    coef_col[1] = cfg.data;
          rgbk_pkg::REG_COEFF_RIGHT:  coef_col[2] = cfg.data;
          rgbk_pkg::REG_FRAME_WIDTH:  width_reg = cfg.data[12:0];
          rgbk_pkg::REG_FRAME_HEIGHT: height_reg = cfg.data[12:0];
          default: ;
        endcase
      end
      if (pix.valid && pix.ready) begin
        if (pix.drain) take_drain();
        else take_pixel({pix.pix_blue, pix.pix_green, pix.pix_red});
      end
    end
    pending = filtered_q.size();
  end

endmodule

### tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;

  // gap ceilings per side, set per frame; 0 gives back-to-back streams
  int   tx_gap_max;
  int   rx_gap_max;
  int   words_out;
  int   stim_count;

  rgbk_pix_if pix_if ();
  rgbk_out_if out_if ();
  rgbk_cfg_if cfg_if ();

  rgb_kernel_convolution_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_if),
    .pix_out (out_if),
    .cfg     (cfg_if)
  );

  rgbk_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .pix        (pix_if),
    .out        (out_if),
    .cfg        (cfg_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  // receiver: random ready gaps, plus one long hold-off once 300 words are out
  // and the sender is offering, so the pipeline backs up and the input stalls
  initial begin
    int n;
    bit held;
    out_if.ready <= 1'b0;
    words_out = 0;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      n = $urandom_range(0, rx_gap_max);
      if (!held && words_out >= 300 && pix_if.valid) begin
        n = 400;
        held = 1'b1;
      end
      if (n > 0) begin
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
      words_out++;
    end
  end

  // one word on the pixel channel; valid stays high when no gap is drawn
  task automatic send_word(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic drn);
    int n;
    n = $urandom_range(0, tx_gap_max);
    if (n > 0) begin
      pix_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    pix_if.valid     <= 1'b1;
    pix_if.pix_red   <= r;
    pix_if.pix_green <= g;
    pix_if.pix_blue  <= b;
    pix_if.drain     <= drn;
    do @(posedge clk); while (!pix_if.ready);
    stim_count++;
  endtask

  task automatic send_pixel(bit extremes);
    if (extremes)
      send_word($urandom_range(0, 1) ? 8'hFF : 8'h00, $urandom_range(0, 1) ? 8'hFF : 8'h00,
                $urandom_range(0, 1) ? 8'hFF : 8'h00, 1'b0);
    else
      send_word(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic cfg_write(rgbk_pkg::cfg_reg_t idx, logic [23:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  // drain the block before touching registers; drains can leave work in flight
  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_frame(logic [23:0] cl, logic [23:0] cm, logic [23:0] cr,
                           logic [23:0] w, logic [23:0] h);
    wait_idle();
    cfg_write(rgbk_pkg::REG_COEFF_LEFT, cl);
    cfg_write(rgbk_pkg::REG_COEFF_MID, cm);
    cfg_write(rgbk_pkg::REG_COEFF_RIGHT, cr);
    cfg_write(rgbk_pkg::REG_FRAME_WIDTH, w);
    cfg_write(rgbk_pkg::REG_FRAME_HEIGHT, h);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // full frame plus the drains that flush its tail; noise words are ignored
  task automatic run_frame(int w_eff, int h_eff, bit extremes, bit noise);
    for (int i = 0; i < w_eff * h_eff; i++) begin
      if (noise && $urandom_range(0, 15) == 0) send_word(8'h00, 8'h00, 8'h00, 1'b1);
      send_pixel(extremes);
    end
    if (noise && $urandom_range(0, 3) == 0) send_pixel(extremes);
    for (int i = 0; i < ((h_eff == 1) ? w_eff : w_eff + 1); i++)
      send_word(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 1'b1);
    if (noise && $urandom_range(0, 3) == 0) send_word(8'hFF, 8'hFF, 8'hFF, 1'b1);
  endtask

  function automatic logic [23:0] rand_coefs();
    logic [23:0] c;
    if ($urandom_range(0, 1)) return 24'($urandom());
    for (int k = 0; k < 3; k++) c[8*k +: 8] = 8'($signed($urandom_range(0, 4)) - 2);
    return c;
  endfunction

  initial begin
    int w, h;
    rst              <= 1'b1;
    pix_if.valid     <= 1'b0;
    pix_if.pix_red   <= '0;
    pix_if.pix_green <= '0;
    pix_if.pix_blue  <= '0;
    pix_if.drain     <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= rgbk_pkg::REG_COEFF_LEFT;
    cfg_if.data      <= '0;
    tx_gap_max = 3;
    rx_gap_max = 3;
    stim_count = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: drain with nothing pending, max positive kernel on 0/255 pixels,
    // pixel after the frame is complete, then max negative kernel
    send_word(8'h12, 8'h34, 8'h56, 1'b1);
    set_frame(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 24'd3, 24'd3);
    for (int i = 0; i < 9; i++)
      send_word((i % 2) ? 8'hFF : 8'h00, (i % 3) ? 8'hFF : 8'h00, 8'hFF, 1'b0);
    send_word(8'hAA, 8'hAA, 8'hAA, 1'b0);
    for (int i = 0; i < 4; i++) send_word(8'h00, 8'h00, 8'h00, 1'b1);
    send_word(8'h00, 8'h00, 8'h00, 1'b1);
    set_frame(24'h808080, 24'h808080, 24'h808080, 24'd3, 24'd3);
    run_frame(3, 3, 1, 0);
    // zero sizes behave as one
    set_frame(24'h000000, 24'h000100, 24'h000000, 24'd0, 24'd0);
    run_frame(1, 1, 0, 0);

    // random frames, mostly small
    stim_count = 0;
    while (stim_count < 1300) begin
      w = $urandom_range(1, 10);
      h = $urandom_range(1, 8);
      tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
      rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
      // random upper bits in the size registers are ignored by the block
      set_frame(rand_coefs(), rand_coefs(), rand_coefs(),
                {11'($urandom()), 13'(w)}, {11'($urandom()), 13'(h)});
      run_frame(w, h, $urandom_range(0, 4) == 0, 1);
    end

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### rgb_kernel_convolution_unit.f
src/rgbk_pkg.sv
src/rgbk_if.sv
src/rgbk_seq.sv
src/rgbk_line_store.sv
src/rgbk_filter.sv
src/rgb_kernel_convolution_unit.sv
tb/sv/rgbk_checker.sv
tb/sv/testbench.sv
